// ----- src/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants for the SYN cookie engine
// Opcodes, SHA-1 round constants, key store layout and the control/status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

	localparam logic [1:0] OP_GEN  = 2'd0;
	localparam logic [1:0] OP_CHK  = 2'd1;
	localparam logic [1:0] OP_LOAD = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	localparam int COUNT_SHIFT_DEF = 24;
	localparam int KEY_WORDS       = 34;
	localparam int SET_WORDS       = 17;
	localparam int MSG_KEY_WORDS   = 12;
	localparam int ROUNDS          = 80;
	localparam int STAGE_ROUNDS    = 20;

	localparam logic [31:0] K_0 = 32'h5A82_7999;
	localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
	localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
	localparam logic [31:0] K_3 = 32'hCA62_C1D6;

	typedef struct packed {
		logic       capture;
		logic       msg_load;
		logic       set;
		logic       key_rd;
		logic [4:0] key_slot;
		logic       round_en;
		logic [6:0] round_idx;
		logic       dig;
		logic       fin_a;
		logic       fin_b;
		logic       fin_c;
		logic       out_wr;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       expired;
	} status_t;

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

`default_nettype wire

// ----- src/scs_ctrl.sv -----
// ----------------------------------------------------------------------------
// scs_ctrl: sequencer for the SYN cookie engine
// Walks generate/check items through message set-up, key fetch, 80 rounds
// and finish steps for one or two hashes, then loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       op,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output scs_pkg::cmd_t         cmd,
	input  wire scs_pkg::status_t status
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MSG   = 4'd1;
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_ROUND = 4'd3;
	localparam logic [3:0] S_DIG   = 4'd4;
	localparam logic [3:0] S_A     = 4'd5;
	localparam logic [3:0] S_B     = 4'd6;
	localparam logic [3:0] S_C     = 4'd7;
	localparam logic [3:0] S_EXP   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0] state_q;
	logic [6:0] cnt_q;
	logic       set_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.set       = set_q;
		cmd.key_slot  = cnt_q[4:0];
		cmd.round_idx = cnt_q;
		case (state_q)
			S_IDLE:  cmd.capture  = in_valid;
			S_MSG:   cmd.msg_load = 1'b1;
			S_FETCH: cmd.key_rd   = (cnt_q < 7'(scs_pkg::SET_WORDS));
			S_ROUND: cmd.round_en = 1'b1;
			S_DIG:   cmd.dig      = 1'b1;
			S_A:     cmd.fin_a    = 1'b1;
			S_B:     cmd.fin_b    = 1'b1;
			S_C:     cmd.fin_c    = 1'b1;
			S_OUT:   cmd.out_wr   = !out_valid_q || out_ready;
			default: cmd.capture  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			set_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_wr)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					set_q <= 1'b0;
					if (in_valid) begin
						if (op inside {scs_pkg::OP_GEN, scs_pkg::OP_CHK})
							state_q <= S_MSG;
						else
							state_q <= S_OUT;
					end
				end
				S_MSG: begin
					cnt_q   <= '0;
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					if (cnt_q == 7'(scs_pkg::SET_WORDS)) begin
						cnt_q   <= '0;
						state_q <= S_ROUND;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_ROUND: begin
					if (cnt_q == 7'(scs_pkg::ROUNDS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIG;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_DIG: state_q <= S_A;
				S_A: state_q <= set_q ? S_OUT : S_B;
				S_B: begin
					if (status.op == scs_pkg::OP_GEN) begin
						set_q   <= 1'b1;
						state_q <= S_MSG;
					end else begin
						state_q <= S_C;
					end
				end
				S_C: state_q <= S_EXP;
				S_EXP: begin
					if (status.expired) begin
						state_q <= S_OUT;
					end else begin
						set_q   <= 1'b1;
						state_q <= S_MSG;
					end
				end
				S_OUT: begin
					if (cmd.out_wr)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_hash_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == scs_pkg::OP_GEN || op == scs_pkg::OP_CHK)
		|=> state_q == S_MSG && !set_q)
		else $error("hash item did not start at message set-up");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROUND |-> cnt_q < 7'(scs_pkg::ROUNDS))
		else $error("round counter out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_wr |-> !out_valid_q || out_ready)
		else $error("result written over one not yet taken");

	a_second_hash: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXP && status.expired |=> state_q == S_OUT)
		else $error("expired check ran second hash");

endmodule

`default_nettype wire

// ----- src/scs_dp.sv -----
// ----------------------------------------------------------------------------
// scs_dp: datapath for the SYN cookie engine
// Key memory, SHA-1 message window and round unit, cookie arithmetic,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_dp #(
	parameter int COUNT_SHIFT = scs_pkg::COUNT_SHIFT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire scs_pkg::cmd_t cmd,
	output scs_pkg::status_t   status,
	input  wire logic          cfg_valid,
	input  wire logic          cfg_index,
	input  wire logic [23:0]   cfg_data,
	input  wire logic [1:0]    op,
	input  wire logic [31:0]   saddr,
	input  wire logic [31:0]   daddr,
	input  wire logic [15:0]   sport,
	input  wire logic [15:0]   dport,
	input  wire logic [31:0]   seq_num,
	input  wire logic [31:0]   minute_count,
	input  wire logic [31:0]   cookie_in,
	input  wire logic [23:0]   mss_data,
	input  wire logic [5:0]    key_index,
	input  wire logic [31:0]   key_word,
	output logic [31:0]        cookie_out,
	output logic [23:0]        recovered_data,
	output logic               expired,
	output logic               data_match
);

	localparam int AGE_W = 32 - COUNT_SHIFT;

	// configuration
	logic [7:0]  max_age_q;
	logic [23:0] expected_q;

	// captured item
	logic [1:0]  op_q;
	logic [31:0] sa_q, da_q, seq_q, cnt_q, ck_q;
	logic [31:0] ports_q;
	logic [23:0] data_q;

	// key memory with registered read
	logic [31:0] key_mem [scs_pkg::KEY_WORDS];
	logic [31:0] rd_s1;
	logic [4:0]  slot_s1;
	logic        fill_s1;
	logic [5:0]  key_addr;

	// hash state
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] dig_q;

	// cookie arithmetic
	logic [31:0] base_q, acc_q, res_q;
	logic [AGE_W-1:0] age_q;
	logic        exp_q;

	logic [31:0] f, k, t, w_new, count1, sum_a;
	logic [AGE_W-1:0] age_d;

	assign key_addr = cmd.set ? 6'(cmd.key_slot) + 6'(scs_pkg::SET_WORDS)
	                          : 6'(cmd.key_slot);

	assign status.op      = op_q;
	assign status.expired = exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q  <= 8'd2;
			expected_q <= 24'd2;
			fill_s1    <= 1'b0;
		end else begin
			fill_s1 <= cmd.key_rd;
			if (cfg_valid) begin
				if (cfg_index)
					expected_q <= cfg_data;
				else
					max_age_q <= cfg_data[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture && op == scs_pkg::OP_LOAD && key_index < 6'(scs_pkg::KEY_WORDS))
			key_mem[key_index] <= key_word;
		if (cmd.key_rd)
			rd_s1 <= key_mem[key_addr];
		slot_s1 <= cmd.key_slot;
	end

	// round function
	always_comb begin
		if (cmd.round_idx < 7'(scs_pkg::STAGE_ROUNDS)) begin
			f = d_q ^ (b_q & (c_q ^ d_q));
			k = scs_pkg::K_0;
		end else if (cmd.round_idx < 7'(2 * scs_pkg::STAGE_ROUNDS)) begin
			f = b_q ^ c_q ^ d_q;
			k = scs_pkg::K_1;
		end else if (cmd.round_idx < 7'(3 * scs_pkg::STAGE_ROUNDS)) begin
			f = (b_q & c_q) | (d_q & (b_q | c_q));
			k = scs_pkg::K_2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = scs_pkg::K_3;
		end
		t     = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_new[30:0], w_new[31]};
	end

	assign count1 = !cmd.set ? 32'd0
	              : (op_q == scs_pkg::OP_GEN) ? cnt_q
	              : cnt_q - {{(32 - AGE_W){1'b0}}, age_q};
	assign age_d  = cnt_q[AGE_W-1:0] - acc_q[31:COUNT_SHIFT];
	assign sum_a  = (op_q == scs_pkg::OP_GEN) ? dig_q + {8'd0, data_q} : acc_q - dig_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			sa_q    <= saddr;
			da_q    <= daddr;
			ports_q <= {sport, dport};
			seq_q   <= seq_num;
			cnt_q   <= minute_count;
			ck_q    <= cookie_in;
			data_q  <= mss_data;
		end
		if (cmd.msg_load) begin
			w_q[0] <= scs_pkg::swap32(sa_q);
			w_q[1] <= scs_pkg::swap32(da_q);
			w_q[2] <= scs_pkg::swap32(ports_q);
			w_q[3] <= scs_pkg::swap32(count1);
		end
		if (fill_s1) begin
			if (slot_s1 < 5'(scs_pkg::MSG_KEY_WORDS)) begin
				w_q[4'(slot_s1) + 4'd4] <= scs_pkg::swap32(rd_s1);
			end else begin
				h_q[3'(slot_s1 - 5'(scs_pkg::MSG_KEY_WORDS))] <= rd_s1;
				case (3'(slot_s1 - 5'(scs_pkg::MSG_KEY_WORDS)))
					3'd0:    a_q <= rd_s1;
					3'd1:    b_q <= rd_s1;
					3'd2:    c_q <= rd_s1;
					3'd3:    d_q <= rd_s1;
					default: e_q <= rd_s1;
				endcase
			end
		end
		if (cmd.round_en) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.dig)
			dig_q <= h_q[1] + b_q;
		if (cmd.fin_a) begin
			if (!cmd.set)
				base_q <= dig_q + seq_q;
			else
				res_q <= {{(32 - COUNT_SHIFT){1'b0}}, sum_a[COUNT_SHIFT-1:0]};
		end
		if (cmd.fin_b)
			acc_q <= (op_q == scs_pkg::OP_GEN) ? base_q + (cnt_q << COUNT_SHIFT)
			                                   : ck_q - base_q;
		if (cmd.out_wr) begin
			cookie_out     <= (op_q == scs_pkg::OP_GEN) ? acc_q + res_q : 32'd0;
			recovered_data <= (op_q == scs_pkg::OP_CHK && !exp_q) ? res_q[23:0] : 24'd0;
			expired        <= (op_q == scs_pkg::OP_CHK) && exp_q;
			data_match     <= (op_q == scs_pkg::OP_CHK) && !exp_q
			                  && (res_q[23:0] == expected_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= 1'b0;
			age_q <= '0;
		end else if (cmd.capture) begin
			exp_q <= 1'b0;
		end else if (cmd.fin_c) begin
			age_q <= age_d;
			exp_q <= {{(32 - AGE_W){1'b0}}, age_d} >= {24'd0, max_age_q};
		end
	end

endmodule

`default_nettype wire

// ----- src/syn_cookie_generate_check.sv -----
// ----------------------------------------------------------------------------
// syn_cookie_generate_check: keyed TCP SYN cookie engine (SHA-1)
// Generates and checks SYN cookies from up to two keyed SHA-1 compressions and
// holds the 34-word key store loaded through the item channel.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | op, addresses, ports, seq, count, cookie,
//          |                      | data, key index and word
//  out     | out_valid/out_ready  | cookie_out, recovered_data, expired,
//          |                      | data_match
//  cfg     | cfg_valid/cfg_ready  | cfg_index (0 max_age, 1 expected_data),
//          |                      | cfg_data
//
// One item at a time. Each hash runs in the shared round unit: message
// set-up, key fetch through the one memory read port, 80 rounds, digest.
// Generate and check run two hashes, an expired check only one; load and
// no-op items run none.
// Reset clears the control and configuration registers; key store is
// undefined until loaded. A pending result holds the last step until taken.
`default_nettype none

module syn_cookie_generate_check #(
	parameter int COUNT_SHIFT = scs_pkg::COUNT_SHIFT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] saddr,
	input  wire logic [31:0] daddr,
	input  wire logic [15:0] sport,
	input  wire logic [15:0] dport,
	input  wire logic [31:0] seq_num,
	input  wire logic [31:0] minute_count,
	input  wire logic [31:0] cookie_in,
	input  wire logic [23:0] mss_data,
	input  wire logic [5:0]  key_index,
	input  wire logic [31:0] key_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      cookie_out,
	output logic [23:0]      recovered_data,
	output logic             expired,
	output logic             data_match,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [23:0] cfg_data
);

	scs_pkg::cmd_t    cmd;
	scs_pkg::status_t status;

	// config writes land at once
	assign cfg_ready = 1'b1;

	scs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	scs_dp #(
		.COUNT_SHIFT (COUNT_SHIFT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op             (op),
		.saddr          (saddr),
		.daddr          (daddr),
		.sport          (sport),
		.dport          (dport),
		.seq_num        (seq_num),
		.minute_count   (minute_count),
		.cookie_in      (cookie_in),
		.mss_data       (mss_data),
		.key_index      (key_index),
		.key_word       (key_word),
		.cookie_out     (cookie_out),
		.recovered_data (recovered_data),
		.expired        (expired),
		.data_match     (data_match)
	);

endmodule

`default_nettype wire
